// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define MDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// condition never holds
`define MDQ_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define MDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define MDQ_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- sv/mdq_pkg.sv -----
// ---------------------------------------------------------------------------
// mdq_pkg
// sizes, codes and types of the multi deque manager
// ---------------------------------------------------------------------------
package mdq_pkg;

  localparam int NUM_QUEUES   = 1024;
  localparam int POOL_ENTRIES = 4096;
  localparam int VW           = 32;
  localparam int QW           = $clog2(NUM_QUEUES);
  localparam int PW           = $clog2(POOL_ENTRIES);
  localparam int CW           = $clog2(POOL_ENTRIES + 1);
  localparam int IN_DW        = ((QW + VW + 7) / 8) * 8;
  localparam int OUT_DW       = ((VW + 7) / 8) * 8;
  localparam int QREC_W       = 1 + 2 * PW;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one queue table row
  typedef struct packed {
    logic          nonempty;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } qrec_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_QRD   = 4'b0100,
    S_ENT   = 4'b1000
  } state_t;

endpackage

// ----- sv/multi_deque_manager.sv -----
// a pop result is loaded in S_ENT after the queue table and entry reads, an error in S_QRD
// a new request is taken only in S_IDLE: after S_QRD for a push, after S_ENT for a pop
// a result waiting on m_tready holds the block only when the next result is due
// reset: synchronous; a clearing pass over all 1024 (NUM_QUEUES) queue rows empties them,
// with s_tready low until it ends
// ---------------------------------------------------------------------------
// multi_deque_manager
// many double-ended queues of signed words sharing one linked entry pool
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_deque_manager (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mdq_pkg::IN_DW-1:0]  s_tdata,  // queue_id, push_value, zero fill
  input  logic [1:0]                 s_tuser,  // req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mdq_pkg::OUT_DW-1:0] m_tdata,  // pop_value
  output logic [1:0]                 m_tuser   // status
);

  import mdq_pkg::*;

  // control state
  state_t        state, state_next;
  logic [QW-1:0] clr_addr;
  logic [CW-1:0] free_top, free_top_next;
  logic [CW-1:0] bump_next, bump_next_next;

  // request registers
  req_t          req;
  logic [QW-1:0] q_id;
  logic [VW-1:0] push_val;
  logic [PW-1:0] e_reg, e_reg_next;

  // result register
  logic          load_out;
  status_t       out_status;
  logic [VW-1:0] out_val;

  // queue table: nonempty mark, head and tail per queue
  logic              q_we;
  logic [QW-1:0]     q_waddr, q_raddr;
  qrec_t             q_wrec, qrd;
  logic [QREC_W-1:0] q_rdata;

  // entry stores and free stack
  logic          v_we, n_we, p_we, fs_we;
  logic [PW-1:0] v_waddr, n_waddr, p_waddr, fs_waddr;
  logic [VW-1:0] v_wdata, v_rdata;
  logic [PW-1:0] n_wdata, p_wdata, fs_wdata;
  logic [PW-1:0] n_rdata, p_rdata, fs_rdata, fs_raddr;
  logic [PW-1:0] e_raddr;

  logic          is_push, have_free, have_bump, out_free;
  logic [PW-1:0] new_e, e_sel;

  mdq_ram #(.WIDTH(QREC_W), .DEPTH(NUM_QUEUES)) u_qtab (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wrec),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  mdq_ram #(.WIDTH(VW), .DEPTH(POOL_ENTRIES)) u_val (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(e_raddr), .rdata(v_rdata)
  );

  mdq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(e_raddr), .rdata(n_rdata)
  );

  mdq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(e_raddr), .rdata(p_rdata)
  );

  mdq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign qrd       = qrec_t'(q_rdata);
  assign is_push   = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
  assign have_free = (free_top != '0);
  assign have_bump = (bump_next < CW'(POOL_ENTRIES));
  // freed entries are reused before never-used ones
  assign new_e     = have_free ? fs_rdata : bump_next[PW-1:0];
  assign e_sel     = (req == REQ_POP_FRONT) ? qrd.head : qrd.tail;
  assign out_free  = !m_tvalid || m_tready;

  // top of the free stack is always read, it only moves when leaving a state
  assign fs_raddr  = PW'(free_top - CW'(1));
  // queue row stays addressed so its read data holds while a request waits
  assign q_raddr   = (state == S_IDLE) ? s_tdata[QW-1:0] : q_id;
  assign e_raddr   = (state == S_QRD) ? e_sel : e_reg;

  always_comb begin
    state_next     = state;
    free_top_next  = free_top;
    bump_next_next = bump_next;
    e_reg_next     = e_reg;
    load_out       = 1'b0;
    out_status     = ST_OK;
    out_val        = '0;
    q_we           = 1'b0;
    q_waddr        = q_id;
    q_wrec         = qrd;
    v_we           = 1'b0;
    v_waddr        = new_e;
    v_wdata        = push_val;
    n_we           = 1'b0;
    n_waddr        = new_e;
    n_wdata        = qrd.head;
    p_we           = 1'b0;
    p_waddr        = new_e;
    p_wdata        = qrd.tail;
    fs_we          = 1'b0;
    fs_waddr       = free_top[PW-1:0];
    fs_wdata       = e_reg;

    case (state)
      S_CLEAR: begin
        // empty every queue row after reset
        q_we    = 1'b1;
        q_waddr = clr_addr;
        q_wrec  = '0;
        if (clr_addr == QW'(NUM_QUEUES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_QRD;
        end
      end

      S_QRD: begin
        if (is_push) begin
          if (!have_free && !have_bump) begin
            // pool exhausted: error result, queue table and pool unchanged
            if (out_free) begin
              load_out   = 1'b1;
              out_status = ST_FULL;
              state_next = S_IDLE;
            end
          end else begin
            if (have_free) begin
              free_top_next = free_top - CW'(1);
            end else begin
              bump_next_next = bump_next + CW'(1);
            end
            v_we       = 1'b1;
            q_we       = 1'b1;
            state_next = S_IDLE;
            if (!qrd.nonempty) begin
              q_wrec = '{nonempty: 1'b1, head: new_e, tail: new_e};
            end else if (req == REQ_PUSH_FRONT) begin
              // link new entry before the old head
              n_we    = 1'b1;
              p_we    = 1'b1;
              p_waddr = qrd.head;
              p_wdata = new_e;
              q_wrec  = '{nonempty: 1'b1, head: new_e, tail: qrd.tail};
            end else begin
              // link new entry after the old tail
              p_we    = 1'b1;
              n_we    = 1'b1;
              n_waddr = qrd.tail;
              n_wdata = new_e;
              q_wrec  = '{nonempty: 1'b1, head: qrd.head, tail: new_e};
            end
          end
        end else if (!qrd.nonempty) begin
          // pop from an empty queue
          if (out_free) begin
            load_out   = 1'b1;
            out_status = ST_EMPTY;
            state_next = S_IDLE;
          end
        end else begin
          e_reg_next = e_sel;
          state_next = S_ENT;
        end
      end

      S_ENT: begin
        // entry value and links are in, unlink and return the entry
        if (out_free) begin
          load_out   = 1'b1;
          out_status = ST_OK;
          out_val    = v_rdata;
          q_we       = 1'b1;
          if (req == REQ_POP_FRONT) begin
            if (e_reg == qrd.tail) begin
              q_wrec.nonempty = 1'b0;
            end else begin
              q_wrec.head = n_rdata;
            end
          end else begin
            if (e_reg == qrd.head) begin
              q_wrec.nonempty = 1'b0;
            end else begin
              q_wrec.tail = p_rdata;
            end
          end
          if (free_top < CW'(POOL_ENTRIES)) begin
            fs_we         = 1'b1;
            free_top_next = free_top + CW'(1);
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      free_top  <= '0;
      bump_next <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      free_top  <= free_top_next;
      bump_next <= bump_next_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + QW'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req      <= req_t'(s_tuser);
      q_id     <= s_tdata[QW-1:0];
      push_val <= s_tdata[QW+VW-1:QW];
    end
    e_reg <= e_reg_next;
    if (load_out) begin
      m_tuser <= out_status;
      m_tdata <= OUT_DW'(out_val);
    end
  end

  // an entry cannot be on the free stack more often than it was handed out
  `MDQ_ASSERT_NEVER(a_free_le_used, clk, rst, free_top > bump_next)

  // a new result never lands on one not yet taken
  `MDQ_ASSERT_IMPL(a_out_no_overwrite, clk, rst, load_out, !m_tvalid || m_tready)

  // an accepted request always goes to the queue table read
  `MDQ_ASSERT_NEXT(a_accept_reads, clk, rst, s_tvalid && s_tready, state == S_QRD)

  // a finished pop returns its entry to the free stack
  `MDQ_ASSERT_NEXT(a_pop_frees, clk, rst, load_out && (state == S_ENT),
                   free_top == $past(free_top) + CW'(1))

endmodule

// ----- sv/mdq_ram.sv -----
// ---------------------------------------------------------------------------
// mdq_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module mdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// stream-level check of the multi deque manager: requests go in from a
// pending list, each accepted request is run through a local deque model,
// and every result coming out is matched against the oldest prediction
// ---------------------------------------------------------------------------
module tb_top;
  import mdq_pkg::*;

  localparam int RANDOM_REQS = 1600;
  localparam int PAUSE_AT    = 600;   // request that waits for all results first
  localparam int HOLD_AT     = 300;   // accepted count that starts the long stall
  localparam int HOLD_CYCLES = 500;
  localparam int CALM_LO     = 800;   // no idling while accepted count is in range
  localparam int CALM_HI     = 1300;
  localparam int LIST_MAX    = 4096;  // room for every request and prediction

  typedef struct {
    req_t                 kind;
    logic [QW-1:0]        qid;
    logic signed [VW-1:0] val;
    bit                   wait_idle;
  } deq_req_s;

  typedef struct {
    status_t              status;
    logic signed [VW-1:0] value;
  } deq_res_s;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_DW-1:0] s_tdata  = '0;
  logic [1:0]       s_tuser  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic [1:0]       m_tuser;

  multi_deque_manager u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // queue_id, push_value, zero fill
    .s_tuser  (s_tuser),   // req_type
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // pop_value
    .m_tuser  (m_tuser)    // status
  );

  always #1 clk = ~clk;

  // requests waiting to be offered, and results predicted but not yet seen
  deq_req_s pending_reqs [LIST_MAX];
  deq_res_s deq_results  [LIST_MAX];
  int       pend_wr = 0;
  int       pend_rd = 0;
  int       res_wr  = 0;
  int       res_rd  = 0;

  int taken_cnt  = 0;
  int mismatches = 0;
  bit calm;

  assign calm = (taken_cnt >= CALM_LO) && (taken_cnt < CALM_HI);

  // ---------------------------------------------------------------------------
  // deque model state: queue table, linked entry pool, free stack, bump counter
  // ---------------------------------------------------------------------------
  bit                   q_live [NUM_QUEUES];
  logic [PW-1:0]        q_head [NUM_QUEUES];
  logic [PW-1:0]        q_tail [NUM_QUEUES];
  logic signed [VW-1:0] slot_val  [POOL_ENTRIES];
  logic [PW-1:0]        slot_next [POOL_ENTRIES];
  logic [PW-1:0]        slot_prev [POOL_ENTRIES];
  logic [PW-1:0]        recycled  [POOL_ENTRIES];
  int                   recycled_cnt = 0;
  int                   fresh_next   = 0;

  // apply one request to the model; returns 1 when it produces a result
  function automatic bit apply_request(input deq_req_s r, output deq_res_s res);
    logic [PW-1:0] e;
    res.status = ST_OK;
    res.value  = '0;
    if (r.kind == REQ_PUSH_FRONT || r.kind == REQ_PUSH_BACK) begin
      // freed entries are reused first, then untouched ones in order
      if (recycled_cnt > 0) begin
        recycled_cnt--;
        e = recycled[recycled_cnt];
      end else if (fresh_next < POOL_ENTRIES) begin
        e = PW'(fresh_next);
        fresh_next++;
      end else begin
        res.status = ST_FULL;
        return 1'b1;
      end
      slot_val[e] = r.val;
      if (!q_live[r.qid]) begin
        q_head[r.qid] = e;
        q_tail[r.qid] = e;
        q_live[r.qid] = 1'b1;
      end else if (r.kind == REQ_PUSH_FRONT) begin
        slot_next[e] = q_head[r.qid];
        slot_prev[q_head[r.qid]] = e;
        q_head[r.qid] = e;
      end else begin
        slot_prev[e] = q_tail[r.qid];
        slot_next[q_tail[r.qid]] = e;
        q_tail[r.qid] = e;
      end
      return 1'b0;
    end
    if (!q_live[r.qid]) begin
      res.status = ST_EMPTY;
      return 1'b1;
    end
    if (r.kind == REQ_POP_FRONT) begin
      e = q_head[r.qid];
      if (e == q_tail[r.qid]) q_live[r.qid] = 1'b0;
      else q_head[r.qid] = slot_next[e];
    end else begin
      e = q_tail[r.qid];
      if (e == q_head[r.qid]) q_live[r.qid] = 1'b0;
      else q_tail[r.qid] = slot_prev[e];
    end
    res.value = slot_val[e];
    recycled[recycled_cnt] = e;
    recycled_cnt++;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: predicts on acceptance, then loads the next request
  // ---------------------------------------------------------------------------
  deq_req_s on_bus;
  deq_res_s outcome;
  bit       busy;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        if (apply_request(on_bus, outcome)) begin
          deq_results[res_wr] = outcome;
          res_wr++;
        end
        taken_cnt <= taken_cnt + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        // a request marked wait_idle is held back until nothing is outstanding
        if (pend_rd != pend_wr &&
            (!pending_reqs[pend_rd].wait_idle || res_rd == res_wr) &&
            (calm || $urandom_range(99) >= 9)) begin
          on_bus = pending_reqs[pend_rd];
          pend_rd++;
          s_tvalid <= 1'b1;
          s_tdata  <= IN_DW'({on_bus.val, on_bus.qid});
          s_tuser  <= on_bus.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side ready: random idling plus one long stall so the block backs up
  // ---------------------------------------------------------------------------
  bit hold_done = 1'b0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && taken_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------
  deq_res_s want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (res_rd == res_wr) begin
        $display("%0t: expected no result, actual status %0d value %h", $time, m_tuser,
                 m_tdata[VW-1:0]);
        mismatches++;
      end else begin
        want = deq_results[res_rd];
        res_rd++;
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[VW-1:0] !== want.value) begin
          $display("%0t: pop_value expected %h actual %h", $time, want.value,
                   m_tdata[VW-1:0]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation; gen_depth only steers the mix, the model decides
  // ---------------------------------------------------------------------------
  int gen_depth [NUM_QUEUES];
  int gen_used = 0;

  task automatic add_req(input req_t kind, input int qid, input logic signed [VW-1:0] val,
                         input bit wait_idle);
    deq_req_s r;
    r.kind      = kind;
    r.qid       = QW'(qid);
    r.val       = val;
    r.wait_idle = wait_idle;
    pending_reqs[pend_wr] = r;
    pend_wr++;
    if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
      if (gen_used < POOL_ENTRIES) begin
        gen_depth[qid]++;
        gen_used++;
      end
    end else if (gen_depth[qid] > 0) begin
      gen_depth[qid]--;
      gen_used--;
    end
  endtask

  function automatic logic signed [VW-1:0] pick_word();
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh00000000;
        default: return 32'shffffffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic req_t any_push();
    return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
  endfunction

  function automatic req_t any_pop();
    return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
  endfunction

  int hot_q  [8];

  initial begin
    int   q;
    bit   want_push;
    req_t kind;

    // directed: empty pops, value extremes at both ends, single-entry pops
    add_req(REQ_POP_FRONT, 0, 0, 1'b0);
    add_req(REQ_POP_BACK, NUM_QUEUES - 1, 0, 1'b0);
    add_req(REQ_PUSH_FRONT, 0, 32'sh7fffffff, 1'b0);
    add_req(REQ_PUSH_BACK, 0, 32'sh80000000, 1'b0);
    add_req(REQ_PUSH_FRONT, 0, 32'shffffffff, 1'b0);
    add_req(REQ_PUSH_BACK, 0, 32'sh00000000, 1'b0);
    add_req(REQ_POP_FRONT, 0, 0, 1'b0);
    add_req(REQ_POP_BACK, 0, 32'sh12345678, 1'b0);
    add_req(REQ_POP_BACK, 0, 0, 1'b0);
    add_req(REQ_POP_BACK, 0, 0, 1'b0);
    add_req(REQ_POP_FRONT, 0, 0, 1'b0);
    add_req(REQ_PUSH_BACK, NUM_QUEUES - 1, 32'sh55555555, 1'b0);
    add_req(REQ_PUSH_FRONT, 'h2aa, 32'shaaaaaaaa, 1'b0);
    add_req(REQ_PUSH_FRONT, 'h155, 32'sh00000001, 1'b0);
    add_req(REQ_POP_FRONT, NUM_QUEUES - 1, 0, 1'b0);
    add_req(REQ_POP_BACK, 'h2aa, 0, 1'b0);
    add_req(REQ_POP_BACK, 'h155, 0, 1'b0);
    add_req(REQ_PUSH_BACK, 'h155, 32'sh80000001, 1'b0);
    add_req(REQ_PUSH_BACK, 'h155, 32'sh7ffffffe, 1'b0);
    add_req(REQ_POP_FRONT, 'h155, 0, 1'b0);
    add_req(REQ_POP_FRONT, 'h155, 0, 1'b0);

    // random mix: mostly a small set of busy queues, some scattered ones
    foreach (hot_q[i]) hot_q[i] = $urandom_range(NUM_QUEUES - 1);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      q = ($urandom_range(99) < 85) ? hot_q[$urandom_range(7)]
                                    : $urandom_range(NUM_QUEUES - 1);
      want_push = (gen_depth[q] == 0) ? ($urandom_range(99) < 85)
                                      : ($urandom_range(99) < 50);
      kind = want_push ? any_push() : any_pop();
      add_req(kind, q, want_push ? pick_word() : $urandom, i == PAUSE_AT);
    end

    // empty whatever is left, from both ends
    for (int i = 0; i < NUM_QUEUES; i++)
      while (gen_depth[i] > 0) add_req(any_pop(), i, $urandom, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // all requests taken and every prediction checked, then a short settle
    while (pend_rd != pend_wr || s_tvalid || res_rd != res_wr)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("FAILURE");
    $finish;
  end

endmodule
